### src/mcc_pkg.sv
// Shared types and constants for the microcode container checker.
`default_nettype none
package mcc_pkg;

  localparam logic [31:0] MAGIC_WORD     = 32'h0041_4d44;
  localparam logic [31:0] TABLE_TYPE_CPU = 32'h0000_0000;
  localparam logic [31:0] PATCH_TYPE_UC  = 32'h0000_0001;
  localparam logic [31:0] ENTRY_BYTES    = 32'd16;
  localparam logic [31:0] MC_HDR_BYTES   = 32'd64;

  // Byte counts at which a header word is complete.
  localparam logic [31:0] WORD0_END = 32'd4;
  localparam logic [31:0] WORD1_END = 32'd8;
  localparam logic [31:0] OUTER_END = 32'd12;

  localparam logic [1:0] KIND_PATCH = 2'd0;
  localparam logic [1:0] KIND_ERROR = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;

  localparam logic [3:0] ERR_NO_OUTER     = 4'd0;
  localparam logic [3:0] ERR_MAGIC        = 4'd1;
  localparam logic [3:0] ERR_TABLE_TYPE   = 4'd2;
  localparam logic [3:0] ERR_TABLE_LEN    = 4'd3;
  localparam logic [3:0] ERR_SHORT_ENTRY  = 4'd4;
  localparam logic [3:0] ERR_SHORT_INNER  = 4'd5;
  localparam logic [3:0] ERR_PATCH_TYPE   = 4'd6;
  localparam logic [3:0] ERR_SHORT_MC_HDR = 4'd7;
  localparam logic [3:0] ERR_SHORT_PAYLD  = 4'd8;

  typedef enum logic [2:0] {
    PH_OUTER,
    PH_ENTRY,
    PH_INNER,
    PH_PAYLOAD,
    PH_DONE
  } phase_t;

  // Parser state. The gather shift is byte_position[1:0] in the header phases.
  typedef struct packed {
    phase_t      phase;
    logic [31:0] byte_position;
    logic [27:0] table_entries_left;
    logic [27:0] patches_left;
    logic [31:0] current_ucode_size;
    logic [31:0] current_ucode_id;
    logic        entry_cpu_zero;
    logic [31:0] field_word;
    logic        magic_bad;
    logic        type_bad;
  } state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  error_code;
    logic [31:0] ucode_id;
    logic [31:0] ucode_size;
    logic        final_res;
  } result_t;

  localparam state_t STATE_RESET = '{
    phase:              PH_OUTER,
    byte_position:      32'd0,
    table_entries_left: 28'd0,
    patches_left:       28'd0,
    current_ucode_size: 32'd0,
    current_ucode_id:   32'd0,
    entry_cpu_zero:     1'b1,
    field_word:         32'd0,
    magic_bad:          1'b0,
    type_bad:           1'b0
  };

endpackage
`default_nettype wire

### src/microcode_container_checker.sv
// Top level of the microcode container checker.
`default_nettype none
// Streaming checker for a microcode container, one byte per request on the
// input channel, end_of_stream on the last byte. It walks the 12-byte outer
// header, the equivalence table, and each patch (8-byte inner header then
// payload), and gives at most one result per byte: a patch report (id from
// payload bytes 4..7, size), an error code, or an empty-table finish. A byte
// is taken every clock while no untaken result waits; the result of a byte
// sits in the output register on the following cycle. The parser state and
// the output register are the only storage. A byte is accepted whenever the
// output register is empty or is being drained in the same cycle, so a
// stalled consumer holds off input only while an untaken result waits. After
// a finish or an error, bytes are swallowed silently until end_of_stream,
// which always brings the checker back to its start state (after giving any
// truncation error).
module microcode_container_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        end_of_stream,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       kind,
  output logic [3:0]       error_code,
  output logic [31:0]      ucode_id,
  output logic [31:0]      ucode_size,
  output logic             final_res
);

  mcc_pkg::state_t  state;
  mcc_pkg::state_t  state_next;
  mcc_pkg::result_t step_res;
  mcc_pkg::result_t result;
  logic             step_valid;
  logic             accept;

  // Input stalls only while the output register holds an untaken result.
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  mcc_step u_step (
    .cur           (state),
    .data_byte     (data_byte),
    .end_of_stream (end_of_stream),
    .nxt           (state_next),
    .res_valid     (step_valid),
    .res           (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mcc_pkg::STATE_RESET;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        state     <= state_next;
        out_valid <= step_valid;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload, loaded only when a byte produces a result.
  always_ff @(posedge clk) begin
    if (accept && step_valid) begin
      result <= step_res;
    end
  end

  assign kind       = result.kind;
  assign error_code = result.error_code;
  assign ucode_id   = result.ucode_id;
  assign ucode_size = result.ucode_size;
  assign final_res  = result.final_res;

endmodule
`default_nettype wire

### src/mcc_step.sv
// Next-state and result logic for one container byte.
`default_nettype none
module mcc_step (
  input  wire mcc_pkg::state_t cur,
  input  wire logic [7:0]      data_byte,
  input  wire logic            end_of_stream,
  output mcc_pkg::state_t      nxt,
  output logic                 res_valid,
  output mcc_pkg::result_t     res
);

  logic [31:0] pos_inc;
  logic [31:0] word;
  logic [4:0]  shamt;
  logic        cpu_zero;
  logic        over;
  logic [27:0] ent_left;
  logic [27:0] pat_left;

  assign pos_inc = cur.byte_position + 32'd1;
  assign shamt   = {cur.byte_position[1:0], 3'b000};
  assign word    = cur.field_word | ({24'd0, data_byte} << shamt);

  always_comb begin
    nxt       = cur;
    res_valid = 1'b0;
    res       = '0;
    cpu_zero  = 1'b1;
    over      = 1'b0;
    ent_left  = '0;
    pat_left  = '0;

    unique case (cur.phase)
      mcc_pkg::PH_OUTER: begin
        nxt.byte_position = pos_inc;
        nxt.field_word    = word;
        if (pos_inc[1:0] == 2'b00) begin
          nxt.field_word = '0;
          if (pos_inc == mcc_pkg::WORD0_END) begin
            nxt.magic_bad = (word != mcc_pkg::MAGIC_WORD);
          end else if (pos_inc == mcc_pkg::WORD1_END) begin
            nxt.type_bad = (word != mcc_pkg::TABLE_TYPE_CPU);
          end else begin
            nxt.byte_position = '0;
            res.final_res     = 1'b1;
            priority if (cur.magic_bad) begin
              res_valid      = 1'b1;
              res.kind       = mcc_pkg::KIND_ERROR;
              res.error_code = mcc_pkg::ERR_MAGIC;
              nxt.phase      = mcc_pkg::PH_DONE;
            end else if (cur.type_bad) begin
              res_valid      = 1'b1;
              res.kind       = mcc_pkg::KIND_ERROR;
              res.error_code = mcc_pkg::ERR_TABLE_TYPE;
              nxt.phase      = mcc_pkg::PH_DONE;
            end else if (word[3:0] != 4'd0) begin
              res_valid      = 1'b1;
              res.kind       = mcc_pkg::KIND_ERROR;
              res.error_code = mcc_pkg::ERR_TABLE_LEN;
              nxt.phase      = mcc_pkg::PH_DONE;
            end else begin
              nxt.table_entries_left = word[31:4];
              nxt.patches_left       = '0;
              if (word[31:4] == 28'd0) begin
                res_valid = 1'b1;
                res.kind  = mcc_pkg::KIND_EMPTY;
                nxt.phase = mcc_pkg::PH_DONE;
              end else begin
                nxt.entry_cpu_zero = 1'b1;
                nxt.phase          = mcc_pkg::PH_ENTRY;
              end
            end
          end
        end
      end

      mcc_pkg::PH_ENTRY: begin
        cpu_zero = cur.entry_cpu_zero &
                   !((cur.byte_position < 32'd4) && (data_byte != 8'd0));
        nxt.entry_cpu_zero = cpu_zero;
        nxt.byte_position  = pos_inc;
        if (pos_inc >= mcc_pkg::ENTRY_BYTES) begin
          nxt.byte_position = '0;
          ent_left = cur.table_entries_left - 28'd1;
          if (cpu_zero) begin
            pat_left = cur.patches_left;
            over     = 1'b1;
          end else begin
            pat_left = cur.patches_left + 28'd1;
            over     = (ent_left == 28'd0);
          end
          nxt.table_entries_left = ent_left;
          nxt.patches_left       = pat_left;
          nxt.entry_cpu_zero     = 1'b1;
          if (over) begin
            if (pat_left == 28'd0) begin
              res_valid     = 1'b1;
              res.kind      = mcc_pkg::KIND_EMPTY;
              res.final_res = 1'b1;
              nxt.phase     = mcc_pkg::PH_DONE;
            end else begin
              nxt.field_word = '0;
              nxt.phase      = mcc_pkg::PH_INNER;
            end
          end
        end
      end

      mcc_pkg::PH_INNER: begin
        nxt.byte_position = pos_inc;
        nxt.field_word    = word;
        if (pos_inc[1:0] == 2'b00) begin
          nxt.field_word = '0;
          if (pos_inc == mcc_pkg::WORD0_END) begin
            nxt.type_bad = (word != mcc_pkg::PATCH_TYPE_UC);
          end else begin
            nxt.byte_position      = '0;
            nxt.current_ucode_size = word;
            res.final_res          = 1'b1;
            priority if (cur.type_bad) begin
              res_valid      = 1'b1;
              res.kind       = mcc_pkg::KIND_ERROR;
              res.error_code = mcc_pkg::ERR_PATCH_TYPE;
              nxt.phase      = mcc_pkg::PH_DONE;
            end else if (word < mcc_pkg::MC_HDR_BYTES) begin
              res_valid      = 1'b1;
              res.kind       = mcc_pkg::KIND_ERROR;
              res.error_code = mcc_pkg::ERR_SHORT_MC_HDR;
              nxt.phase      = mcc_pkg::PH_DONE;
            end else begin
              nxt.current_ucode_id = '0;
              nxt.phase            = mcc_pkg::PH_PAYLOAD;
            end
          end
        end
      end

      mcc_pkg::PH_PAYLOAD: begin
        if ((cur.byte_position >= 32'd4) && (cur.byte_position < 32'd8)) begin
          nxt.current_ucode_id = cur.current_ucode_id | ({24'd0, data_byte} << shamt);
        end
        nxt.byte_position = pos_inc;
        if (pos_inc >= cur.current_ucode_size) begin
          nxt.byte_position = '0;
          pat_left          = cur.patches_left - 28'd1;
          nxt.patches_left  = pat_left;
          res_valid         = 1'b1;
          res.kind          = mcc_pkg::KIND_PATCH;
          res.ucode_id      = nxt.current_ucode_id;
          res.ucode_size    = cur.current_ucode_size;
          if (pat_left == 28'd0) begin
            res.final_res = 1'b1;
            nxt.phase     = mcc_pkg::PH_DONE;
          end else begin
            res.final_res  = end_of_stream;
            nxt.field_word = '0;
            nxt.type_bad   = 1'b0;
            nxt.phase      = mcc_pkg::PH_INNER;
          end
        end
      end

      mcc_pkg::PH_DONE: begin
        nxt.phase = mcc_pkg::PH_DONE;
      end

      default: begin
        nxt.phase = mcc_pkg::PH_DONE;
      end
    endcase

    // Final byte: report the truncation of the phase reached, then restart.
    if (end_of_stream) begin
      if (!res_valid) begin
        res           = '0;
        res.kind      = mcc_pkg::KIND_ERROR;
        res.final_res = 1'b1;
        unique case (nxt.phase)
          mcc_pkg::PH_OUTER: begin
            res_valid      = 1'b1;
            res.error_code = mcc_pkg::ERR_NO_OUTER;
          end
          mcc_pkg::PH_ENTRY: begin
            res_valid      = 1'b1;
            res.error_code = mcc_pkg::ERR_SHORT_ENTRY;
          end
          mcc_pkg::PH_INNER: begin
            res_valid      = 1'b1;
            res.error_code = mcc_pkg::ERR_SHORT_INNER;
          end
          mcc_pkg::PH_PAYLOAD: begin
            res_valid      = 1'b1;
            res.error_code = (nxt.byte_position < mcc_pkg::MC_HDR_BYTES) ?
                             mcc_pkg::ERR_SHORT_MC_HDR : mcc_pkg::ERR_SHORT_PAYLD;
          end
          default: begin
            res_valid = 1'b0;
          end
        endcase
      end
      nxt = mcc_pkg::STATE_RESET;
    end
  end

endmodule
`default_nettype wire

### sim/mcc_parse_checker.sv
// Watches both request channels, predicts each result and compares field by field.
module mcc_parse_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        end_of_stream,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  kind,
  input  logic [3:0]  error_code,
  input  logic [31:0] ucode_id,
  input  logic [31:0] ucode_size,
  input  logic        final_res,
  output int          mismatches,
  output int          results_due
);
  timeunit 1ns;
  timeprecision 1ps;

  // Own copy of the parser state.
  mcc_pkg::phase_t ph;
  logic [31:0]     pos;
  logic [31:0]     shift;
  logic [31:0]     word;
  logic [27:0]     entries_left;
  logic [27:0]     patches_due;
  logic [31:0]     psize;
  logic [31:0]     pid;
  logic            cpu_zero;
  logic            magic_bad;
  logic            type_bad;

  mcc_pkg::result_t due_results[$];

  task automatic reset_parser();
    ph           = mcc_pkg::PH_OUTER;
    pos          = '0;
    shift        = '0;
    word         = '0;
    entries_left = '0;
    patches_due  = '0;
    psize        = '0;
    pid          = '0;
    cpu_zero     = 1'b1;
    magic_bad    = 1'b0;
    type_bad     = 1'b0;
  endtask

  function automatic mcc_pkg::result_t error_result(input logic [3:0] code);
    mcc_pkg::result_t r;
    r            = '0;
    r.kind       = mcc_pkg::KIND_ERROR;
    r.error_code = code;
    r.final_res  = 1'b1;
    return r;
  endfunction

  function automatic mcc_pkg::result_t empty_result();
    mcc_pkg::result_t r;
    r           = '0;
    r.kind      = mcc_pkg::KIND_EMPTY;
    r.final_res = 1'b1;
    return r;
  endfunction

  // Little-endian word assembly; true once four bytes are in.
  function automatic bit take_into_word(input logic [7:0] b);
    word  = word | (32'(b) << shift[4:0]);
    shift = shift + 32'd8;
    if (shift >= 32'd32) begin
      shift = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic parse_byte(input logic [7:0] b, input logic eos);
    mcc_pkg::result_t r;
    bit               got;
    bit               over;
    logic [31:0]      w;
    r   = '0;
    got = 1'b0;
    case (ph)
      mcc_pkg::PH_OUTER: begin
        pos = pos + 32'd1;
        if (take_into_word(b)) begin
          w    = word;
          word = '0;
          if (pos == mcc_pkg::WORD0_END) begin
            magic_bad = (w != mcc_pkg::MAGIC_WORD);
          end else if (pos == mcc_pkg::WORD1_END) begin
            type_bad = (w != mcc_pkg::TABLE_TYPE_CPU);
          end else begin
            pos = '0;
            got = 1'b1;
            ph  = mcc_pkg::PH_DONE;
            if (magic_bad) begin
              r = error_result(mcc_pkg::ERR_MAGIC);
            end else if (type_bad) begin
              r = error_result(mcc_pkg::ERR_TABLE_TYPE);
            end else if (w[3:0] != 4'd0) begin
              r = error_result(mcc_pkg::ERR_TABLE_LEN);
            end else begin
              entries_left = w[31:4];
              patches_due  = '0;
              if (entries_left == '0) begin
                r = empty_result();
              end else begin
                got      = 1'b0;
                cpu_zero = 1'b1;
                ph       = mcc_pkg::PH_ENTRY;
              end
            end
          end
        end
      end
      mcc_pkg::PH_ENTRY: begin
        if (pos < 32'd4 && b != 8'd0) cpu_zero = 1'b0;
        pos = pos + 32'd1;
        if (pos >= mcc_pkg::ENTRY_BYTES) begin
          pos          = '0;
          entries_left = entries_left - 28'd1;
          if (cpu_zero) begin
            over = 1'b1;
          end else begin
            patches_due = patches_due + 28'd1;
            over        = (entries_left == '0);
          end
          cpu_zero = 1'b1;
          if (over) begin
            if (patches_due == '0) begin
              r   = empty_result();
              got = 1'b1;
              ph  = mcc_pkg::PH_DONE;
            end else begin
              shift = '0;
              word  = '0;
              ph    = mcc_pkg::PH_INNER;
            end
          end
        end
      end
      mcc_pkg::PH_INNER: begin
        pos = pos + 32'd1;
        if (take_into_word(b)) begin
          w    = word;
          word = '0;
          if (pos == mcc_pkg::WORD0_END) begin
            type_bad = (w != mcc_pkg::PATCH_TYPE_UC);
          end else begin
            pos   = '0;
            psize = w;
            if (type_bad) begin
              r   = error_result(mcc_pkg::ERR_PATCH_TYPE);
              got = 1'b1;
              ph  = mcc_pkg::PH_DONE;
            end else if (w < mcc_pkg::MC_HDR_BYTES) begin
              r   = error_result(mcc_pkg::ERR_SHORT_MC_HDR);
              got = 1'b1;
              ph  = mcc_pkg::PH_DONE;
            end else begin
              pid = '0;
              ph  = mcc_pkg::PH_PAYLOAD;
            end
          end
        end
      end
      mcc_pkg::PH_PAYLOAD: begin
        // id word sits in payload bytes 4..7
        if (pos >= 32'd4 && pos < 32'd8) pid[8*pos[1:0] +: 8] = b;
        pos = pos + 32'd1;
        if (pos >= psize) begin
          pos          = '0;
          patches_due  = patches_due - 28'd1;
          got          = 1'b1;
          r.kind       = mcc_pkg::KIND_PATCH;
          r.ucode_id   = pid;
          r.ucode_size = psize;
          if (patches_due == '0) begin
            r.final_res = 1'b1;
            ph          = mcc_pkg::PH_DONE;
          end else begin
            r.final_res = eos;
            shift       = '0;
            word        = '0;
            type_bad    = 1'b0;
            ph          = mcc_pkg::PH_INNER;
          end
        end
      end
      default: ph = mcc_pkg::PH_DONE;
    endcase

    if (eos) begin
      // truncation errors only when the byte gave nothing itself
      if (!got) begin
        got = 1'b1;
        case (ph)
          mcc_pkg::PH_OUTER:   r = error_result(mcc_pkg::ERR_NO_OUTER);
          mcc_pkg::PH_ENTRY:   r = error_result(mcc_pkg::ERR_SHORT_ENTRY);
          mcc_pkg::PH_INNER:   r = error_result(mcc_pkg::ERR_SHORT_INNER);
          mcc_pkg::PH_PAYLOAD: r = error_result(pos < mcc_pkg::MC_HDR_BYTES ?
                                                mcc_pkg::ERR_SHORT_MC_HDR :
                                                mcc_pkg::ERR_SHORT_PAYLD);
          default:             got = 1'b0;
        endcase
      end
      reset_parser();
    end
    if (got) due_results = {due_results, r};
  endtask

  task automatic flag_mismatch(input string what, input logic [31:0] seen,
                               input logic [31:0] want);
    if (mismatches < 100)
      $display("%0t ns  %s: got %0h, want %0h", $time, what, seen, want);
    mismatches++;
  endtask

  task automatic check_result();
    mcc_pkg::result_t want;
    if (due_results.size() == 0) begin
      flag_mismatch("result with nothing due, kind", 32'(kind), 32'd0);
      return;
    end
    want = due_results.pop_front();
    if (kind !== want.kind) flag_mismatch("kind", 32'(kind), 32'(want.kind));
    if (error_code !== want.error_code)
      flag_mismatch("error_code", 32'(error_code), 32'(want.error_code));
    if (ucode_id !== want.ucode_id)
      flag_mismatch("ucode_id", ucode_id, want.ucode_id);
    if (ucode_size !== want.ucode_size)
      flag_mismatch("ucode_size", ucode_size, want.ucode_size);
    if (final_res !== want.final_res)
      flag_mismatch("final_res", 32'(final_res), 32'(want.final_res));
  endtask

  // A result leaving at this edge was caused by an earlier request, so the
  // output side is settled before the new request is parsed.
  always @(posedge clk) begin
    if (rst) begin
      mismatches = 0;
      reset_parser();
      due_results.delete();
    end else begin
      if (out_valid && out_ready) check_result();
      if (in_valid && in_ready) parse_byte(data_byte, end_of_stream);
    end
    results_due <= due_results.size();
  end

endmodule

### sim/tb_microcode_container_checker.sv
// Stimulus, flow control and verdict for the microcode container checker.
module tb_microcode_container_checker;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'd0;
  logic        end_of_stream = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  kind;
  logic [3:0]  error_code;
  logic [31:0] ucode_id;
  logic [31:0] ucode_size;
  logic        final_res;

  int mismatches;
  int results_due;

  // Flow-control knobs, in percent per cycle.
  int idle_pct = 0;
  int stall_pct = 0;
  // The stimulus bumps the ticket; the receiver process serves it with a
  // long hold-off counted in its own cycles.
  int hold_ticket = 0;
  int hold_seen = 0;
  int hold_left = 0;

  int bytes_sent = 0;
  int containers = 0;

  // Bytes of the container being put together.
  logic [7:0] stream_q[$];

  microcode_container_checker dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .data_byte     (data_byte),
    .end_of_stream (end_of_stream),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .kind          (kind),
    .error_code    (error_code),
    .ucode_id      (ucode_id),
    .ucode_size    (ucode_size),
    .final_res     (final_res)
  );

  mcc_parse_checker watch (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .data_byte     (data_byte),
    .end_of_stream (end_of_stream),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .kind          (kind),
    .error_code    (error_code),
    .ucode_id      (ucode_id),
    .ucode_size    (ucode_size),
    .final_res     (final_res),
    .mismatches    (mismatches),
    .results_due   (results_due)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver side. Long hold-off first, otherwise random stalls.
  always @(posedge clk) begin
    if (hold_seen != hold_ticket) begin
      hold_seen <= hold_ticket;
      hold_left <= 400;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Offers one byte request and returns just after the edge that takes it.
  // in_ready is sampled at the falling edge, where every input is settled.
  task automatic send_byte(input logic [7:0] b, input logic last);
    bit taken;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    data_byte     <= b;
    end_of_stream <= last;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
    bytes_sent++;
  endtask

  // Sends the assembled container, flagging its last byte. The idling phase
  // moves on with every container.
  task automatic ship();
    case (containers % 4)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 71; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 71; end
      default: begin idle_pct = 7; stall_pct = 7; end
    endcase
    foreach (stream_q[i]) send_byte(stream_q[i], i == stream_q.size() - 1);
    stream_q.delete();
    containers++;
  endtask

  // Holds the sender off until every predicted result has come out.
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (results_due != 0);
    @(posedge clk);
  endtask

  task automatic add_byte(input logic [7:0] b);
    stream_q = {stream_q, b};
  endtask

  task automatic add_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) add_byte(w[8*i +: 8]);
  endtask

  task automatic add_random(input int n);
    repeat (n) add_byte(8'($urandom));
  endtask

  task automatic add_outer(input logic [31:0] magic, input logic [31:0] ttype,
                           input logic [31:0] tlen);
    add_word(magic);
    add_word(ttype);
    add_word(tlen);
  endtask

  // Equivalence entry: CPU word then 12 bytes the parser does not look at.
  task automatic add_entry(input logic [31:0] cpu);
    add_word(cpu);
    add_random(12);
  endtask

  // Inner header and, for sane sizes, the payload with the id in bytes 4..7.
  task automatic add_patch(input logic [31:0] ptype, input logic [31:0] size,
                           input logic [31:0] id);
    add_word(ptype);
    add_word(size);
    if (size >= mcc_pkg::MC_HDR_BYTES && size <= 32'd8192)
      for (int j = 0; j < int'(size); j++)
        add_byte((j >= 4 && j < 8) ? id[8*(j-4) +: 8] : 8'($urandom));
  endtask

  task automatic cut_to(input int n);
    stream_q = stream_q[0:n-1];
  endtask

  function automatic logic [31:0] cpu_word();
    logic [31:0] c;
    c = $urandom;
    if (c == '0) c = 32'h0000_0100;
    return c;
  endfunction

  // One random container. Mostly well formed so that the deep phases are
  // reached; the rest is noise, header faults and truncated streams.
  task automatic random_container();
    int          shape;
    int          n_ent;
    int          zero_at;
    int          n_patch;
    logic [31:0] magic;
    logic [31:0] ttype;
    logic [31:0] tlen;
    logic [31:0] ptype;
    logic [31:0] size;
    shape = $urandom_range(99);
    if (shape < 20) begin
      // noise, half of it behind a good magic word
      if ($urandom_range(1)) add_word(mcc_pkg::MAGIC_WORD);
      add_random($urandom_range(1, 16));
    end else begin
      n_ent   = ($urandom_range(3) == 0) ? $urandom_range(2, 3) : 1;
      zero_at = ($urandom_range(4) == 0) ? $urandom_range(0, n_ent - 1) : n_ent;
      magic   = ($urandom_range(99) < 4) ? 32'($urandom) : mcc_pkg::MAGIC_WORD;
      ttype   = ($urandom_range(99) < 4) ? 32'($urandom) : mcc_pkg::TABLE_TYPE_CPU;
      tlen    = 32'(n_ent) * mcc_pkg::ENTRY_BYTES;
      if ($urandom_range(99) < 4) tlen = tlen + 32'($urandom_range(1, 15));
      add_outer(magic, ttype, tlen);
      for (int i = 0; i < n_ent; i++) begin
        if (i == zero_at) begin
          add_entry('0);
          break;
        end
        add_entry(cpu_word());
      end
      n_patch = (zero_at < n_ent) ? zero_at : n_ent;
      for (int p = 0; p < n_patch; p++) begin
        ptype = ($urandom_range(99) < 3) ? 32'($urandom) : mcc_pkg::PATCH_TYPE_UC;
        shape = $urandom_range(99);
        if (shape < 5)       size = 32'($urandom_range(0, 63));
        else if (shape < 9)  size = 32'($urandom_range(100, 400));
        else                 size = 32'($urandom_range(64, 72));
        add_patch(ptype, size, $urandom);
      end
      if ($urandom_range(99) < 20) add_random($urandom_range(1, 6));
      if ($urandom_range(99) < 25 && stream_q.size() > 1)
        cut_to($urandom_range(1, stream_q.size() - 1));
    end
    ship();
  endtask

  initial begin
    #2_000_000;
    $display("microcode_container_checker: mismatch");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- directed containers ----
    // lone final byte: no outer header
    add_byte(8'hff);
    ship();
    // each outer header fault
    add_outer(32'h1234_5678, mcc_pkg::TABLE_TYPE_CPU, 32'd16);
    ship();
    add_outer(mcc_pkg::MAGIC_WORD, 32'hffff_ffff, 32'd16);
    ship();
    add_outer(mcc_pkg::MAGIC_WORD, mcc_pkg::TABLE_TYPE_CPU, 32'd17);
    ship();
    // zero length, then bytes after the finish that must be swallowed
    add_outer(mcc_pkg::MAGIC_WORD, mcc_pkg::TABLE_TYPE_CPU, 32'd0);
    add_byte(8'h00);
    add_byte(8'hff);
    add_random(2);
    ship();
    // first entry has a zero CPU word: empty finish
    add_outer(mcc_pkg::MAGIC_WORD, mcc_pkg::TABLE_TYPE_CPU, 32'd32);
    add_entry('0);
    ship();
    // huge table length ended early by a zero CPU word
    add_outer(mcc_pkg::MAGIC_WORD, mcc_pkg::TABLE_TYPE_CPU, 32'hffff_fff0);
    add_entry(32'hffff_ffff);
    add_entry('0);
    add_patch(mcc_pkg::PATCH_TYPE_UC, 32'd64, 32'hffff_ffff);
    ship();
    // single minimum size patch
    add_outer(mcc_pkg::MAGIC_WORD, mcc_pkg::TABLE_TYPE_CPU, 32'd16);
    add_entry(32'h0000_0001);
    add_patch(mcc_pkg::PATCH_TYPE_UC, 32'd64, 32'h0000_0000);
    ship();
    // two patches due, final byte lands on the end of the first
    add_outer(mcc_pkg::MAGIC_WORD, mcc_pkg::TABLE_TYPE_CPU, 32'd32);
    add_entry(32'h8000_0000);
    add_entry(32'h0000_0f10);
    add_patch(mcc_pkg::PATCH_TYPE_UC, 32'd64, 32'h5a5a_a5a5);
    add_patch(mcc_pkg::PATCH_TYPE_UC, 32'd64, 32'h0102_0304);
    cut_to(12 + 32 + 8 + 64);
    ship();
    // bad patch type, stream ending on the inner header
    add_outer(mcc_pkg::MAGIC_WORD, mcc_pkg::TABLE_TYPE_CPU, 32'd16);
    add_entry(32'h0080_0f00);
    add_patch(32'hffff_ffff, 32'd64, 32'h1111_2222);
    cut_to(12 + 16 + 8);
    ship();
    // patch sizes below the microcode header
    add_outer(mcc_pkg::MAGIC_WORD, mcc_pkg::TABLE_TYPE_CPU, 32'd16);
    add_entry(32'h0000_00ff);
    add_patch(mcc_pkg::PATCH_TYPE_UC, 32'd63, '0);
    ship();
    add_outer(mcc_pkg::MAGIC_WORD, mcc_pkg::TABLE_TYPE_CPU, 32'd16);
    add_entry(32'h00ff_0000);
    add_patch(mcc_pkg::PATCH_TYPE_UC, 32'd0, '0);
    ship();
    // truncated inside an entry
    add_outer(mcc_pkg::MAGIC_WORD, mcc_pkg::TABLE_TYPE_CPU, 32'd16);
    add_entry(cpu_word());
    cut_to(12 + 7);
    ship();
    // truncated inside the inner header
    add_outer(mcc_pkg::MAGIC_WORD, mcc_pkg::TABLE_TYPE_CPU, 32'd16);
    add_entry(cpu_word());
    add_patch(mcc_pkg::PATCH_TYPE_UC, 32'd64, '0);
    cut_to(12 + 16 + 3);
    ship();
    // truncated before the microcode header is complete, largest size
    add_outer(mcc_pkg::MAGIC_WORD, mcc_pkg::TABLE_TYPE_CPU, 32'd16);
    add_entry(cpu_word());
    add_patch(mcc_pkg::PATCH_TYPE_UC, 32'hffff_ffff, '0);
    add_random(10);
    ship();
    // truncated past the microcode header
    add_outer(mcc_pkg::MAGIC_WORD, mcc_pkg::TABLE_TYPE_CPU, 32'd16);
    add_entry(cpu_word());
    add_patch(mcc_pkg::PATCH_TYPE_UC, 32'd200, 32'hdead_beef);
    cut_to(12 + 16 + 8 + 100);
    ship();
    // one larger patch and a run of three
    add_outer(mcc_pkg::MAGIC_WORD, mcc_pkg::TABLE_TYPE_CPU, 32'd16);
    add_entry(cpu_word());
    add_patch(mcc_pkg::PATCH_TYPE_UC, 32'd128, 32'h7e57_c0de);
    ship();
    add_outer(mcc_pkg::MAGIC_WORD, mcc_pkg::TABLE_TYPE_CPU, 32'd48);
    repeat (3) add_entry(cpu_word());
    repeat (3) add_patch(mcc_pkg::PATCH_TYPE_UC, 32'($urandom_range(64, 80)), $urandom);
    ship();

    // ---- back pressure: receiver shut for a long stretch while short
    // erroring requests keep coming, so the output register fills and the
    // input stalls; then wait for everything to drain ----
    hold_ticket++;
    repeat (30) begin
      add_random(1);
      ship();
    end
    drain();

    // ---- random containers, idling phase rotating per container ----
    while (bytes_sent < 1500) random_container();

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("microcode_container_checker: match");
    else
      $display("microcode_container_checker: mismatch");
    $finish;
  end

endmodule
